// ----- design/rcpf_pkg.sv -----
// shared constants, types and a helper function for the clipped rectangle pattern fill
package rcpf_pkg;

   localparam int COORD_BITS     = 11;
   localparam int RECT_BITS      = 12;
   localparam int CALC_BITS      = RECT_BITS + 2;
   localparam int COLOR_BITS     = 16;
   localparam int PAT_BITS       = 64;
   localparam int MAX_PAT_ROWS   = 8;
   localparam int PROW_BITS      = 3;
   localparam int PROWS_REG_BITS = 4;
   localparam int MOD_CNT_BITS   = $clog2(COORD_BITS);
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 64;
   localparam int REQ_DATA_BITS  = 48;
   localparam int RSP_DATA_BITS  = 64;
   localparam int RSP_USED_BITS  = 4 * COORD_BITS + COLOR_BITS;

   // register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_FILL_MODE     = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_FORE_COLOR    = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_BACK_COLOR    = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PATTERN_BITS  = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PATTERN_ROWS  = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SCREEN_WIDTH  = 3'd5;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SCREEN_HEIGHT = 3'd6;

   // request and response kinds and fill modes
   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_ADVANCE = 1'b1;
   localparam logic RES_WINDOW   = 1'b0;
   localparam logic RES_PIXEL    = 1'b1;
   localparam logic MODE_SOLID   = 1'b0;
   localparam logic MODE_PATTERN = 1'b1;

   typedef logic [COORD_BITS-1:0]        coord_type;
   typedef logic signed [CALC_BITS-1:0]  calc_type;

   typedef enum logic [2:0] {
      ST_READY,
      ST_CLIP1,
      ST_CLIP2,
      ST_CHECK,
      ST_MOD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                      fill_mode;
      logic [COLOR_BITS-1:0]     fore_color;
      logic [COLOR_BITS-1:0]     back_color;
      logic [PAT_BITS-1:0]       pattern_bits;
      logic [PROWS_REG_BITS-1:0] pattern_rows;
      coord_type                 screen_width;
      coord_type                 screen_height;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic clip1;
      logic clip2;
      logic check;
      logic mod_step;
      logic pixel;
      logic window;
   } cmd_type;

   typedef struct packed {
      logic rect_ok;
      logic mod_last;
      logic out_free;
   } sts_type;

   // row period actually used: zero acts as one, large values saturate
   function automatic logic [PROWS_REG_BITS-1:0] eff_rows(
      input logic [PROWS_REG_BITS-1:0] rows);
      logic [PROWS_REG_BITS-1:0] res;
      if (rows == '0) begin
         res = PROWS_REG_BITS'(1);
      end else if (rows > PROWS_REG_BITS'(MAX_PAT_ROWS)) begin
         res = PROWS_REG_BITS'(MAX_PAT_ROWS);
      end else begin
         res = rows;
      end
      return res;
   endfunction

endpackage

// ----- design/rcpf_csr.sv -----
// configuration register file of the rectangle fill
module rcpf_csr import rcpf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_FILL_MODE:     cfg_in.fill_mode     = csr_wdata[0];
            CSR_FORE_COLOR:    cfg_in.fore_color    = csr_wdata[COLOR_BITS-1:0];
            CSR_BACK_COLOR:    cfg_in.back_color    = csr_wdata[COLOR_BITS-1:0];
            CSR_PATTERN_BITS:  cfg_in.pattern_bits  = csr_wdata[PAT_BITS-1:0];
            CSR_PATTERN_ROWS:  cfg_in.pattern_rows  = csr_wdata[PROWS_REG_BITS-1:0];
            CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_wdata[COORD_BITS-1:0];
            CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_wdata[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fill_mode     <= MODE_SOLID;
         cfg_ff.fore_color    <= '1;
         cfg_ff.back_color    <= '0;
         cfg_ff.pattern_bits  <= '0;
         cfg_ff.pattern_rows  <= PROWS_REG_BITS'(8);
         cfg_ff.screen_width  <= COORD_BITS'(320);
         cfg_ff.screen_height <= COORD_BITS'(480);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/rcpf_ctrl.sv -----
// controller state machine: sequences clipping, the row remainder and result loads
module rcpf_ctrl import rcpf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   input  logic    req_kind,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_READY: begin
            if (req_tvalid && sts.out_free && req_kind == KIND_START) begin
               state_in = ST_CLIP1;
            end
         end
         ST_CLIP1: state_in = ST_CLIP2;
         ST_CLIP2: state_in = ST_CHECK;
         ST_CHECK: state_in = sts.rect_ok ? ST_MOD : ST_READY;
         ST_MOD: begin
            if (sts.mod_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               state_in = ST_READY;
            end
         end
         default: state_in = ST_READY;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_READY: begin
            req_tready = sts.out_free;
            if (req_tvalid && sts.out_free) begin
               if (req_kind == KIND_START) begin
                  cmd.capture = 1'b1;
               end else begin
                  cmd.pixel = 1'b1;
               end
            end
         end
         ST_CLIP1: cmd.clip1    = 1'b1;
         ST_CLIP2: cmd.clip2    = 1'b1;
         ST_CHECK: cmd.check    = 1'b1;
         ST_MOD:   cmd.mod_step = 1'b1;
         ST_EMIT:  cmd.window   = sts.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_READY;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/rcpf_dp.sv -----
// datapath: clipping, pattern row remainder, pixel walker and response register
module rcpf_dp import rcpf_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output sts_type                     sts,
   input  cfg_type                     cfg,
   input  logic signed [RECT_BITS-1:0] rect_left,
   input  logic signed [RECT_BITS-1:0] rect_top,
   input  logic signed [RECT_BITS-1:0] rect_width,
   input  logic signed [RECT_BITS-1:0] rect_height,
   input  logic                        rsp_tready,
   output logic                        rsp_tvalid,
   output logic [RSP_DATA_BITS-1:0]    rsp_tdata,
   output logic                        rsp_tuser,
   output logic                        rsp_tlast
);

   // rectangle under clipping: x/y become the clipped corner, w/h the exclusive end
   calc_type rx_ff, rx_in, ry_ff, ry_in, rw_ff, rw_in, rh_ff, rh_in;
   logic     rej_ff, rej_in;

   coord_type clip_left_ff, clip_left_in, clip_right_ff, clip_right_in;
   coord_type clip_bottom_ff, clip_bottom_in, cur_col_ff, cur_col_in;
   coord_type cur_row_ff, cur_row_in;
   logic [PROW_BITS-1:0] prow_ff, prow_in;
   logic busy_ff, busy_in;

   // restoring remainder unit, one dividend bit per cycle
   coord_type               mod_y_ff, mod_y_in;
   logic [PROW_BITS-1:0]    rem_ff, rem_in;
   logic [MOD_CNT_BITS-1:0] mod_cnt_ff, mod_cnt_in;
   logic [PROW_BITS:0]      rem_trial;
   logic [PROWS_REG_BITS-1:0] rows_eff;
   logic [PROW_BITS-1:0]    rem_next;

   logic                     out_valid_ff, out_valid_in;
   logic                     out_kind_ff, out_kind_in;
   logic                     out_last_ff, out_last_in;
   coord_type                out_col_ff, out_col_in, out_row_ff, out_row_in;
   coord_type                out_right_ff, out_right_in, out_bottom_ff, out_bottom_in;
   logic [COLOR_BITS-1:0]    out_color_ff, out_color_in;

   calc_type sw_ext, sh_ext, ex_sum, ey_sum;
   logic     pix_last, pat_bit;
   logic [COLOR_BITS-1:0] pix_color;
   logic [PROWS_REG_BITS-1:0] prow_inc;

   assign sw_ext   = $signed({{(CALC_BITS-COORD_BITS){1'b0}}, cfg.screen_width});
   assign sh_ext   = $signed({{(CALC_BITS-COORD_BITS){1'b0}}, cfg.screen_height});
   assign ex_sum   = rx_ff + rw_ff;
   assign ey_sum   = ry_ff + rh_ff;
   assign rows_eff = eff_rows(cfg.pattern_rows);

   assign rem_trial = {rem_ff, mod_y_ff[COORD_BITS-1]};
   assign rem_next  = (rem_trial >= rows_eff) ? PROW_BITS'(rem_trial - rows_eff)
                                              : rem_trial[PROW_BITS-1:0];

   // pattern bit index 63 - 8*row - col is the bitwise inverse of {row, col}
   assign pat_bit   = cfg.pattern_bits[{~prow_ff, ~cur_col_ff[2:0]}];
   assign pix_color = (cfg.fill_mode == MODE_PATTERN && !pat_bit) ? cfg.back_color
                                                                 : cfg.fore_color;
   assign pix_last  = (cur_col_ff == clip_right_ff) && (cur_row_ff == clip_bottom_ff);
   assign prow_inc  = PROWS_REG_BITS'(prow_ff) + PROWS_REG_BITS'(1);

   assign sts.rect_ok  = !rej_ff && (rw_ff > rx_ff) && (rh_ff > ry_ff);
   assign sts.mod_last = (mod_cnt_ff == '0);
   assign sts.out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      rx_in = rx_ff;
      ry_in = ry_ff;
      rw_in = rw_ff;
      rh_in = rh_ff;
      rej_in = rej_ff;
      if (cmd.capture) begin
         rx_in = CALC_BITS'(rect_left);
         ry_in = CALC_BITS'(rect_top);
         rw_in = CALC_BITS'(rect_width);
         rh_in = CALC_BITS'(rect_height);
      end
      if (cmd.clip1) begin
         rej_in = (rw_ff <= 0) || (rh_ff <= 0)
                  || (cfg.fill_mode == MODE_PATTERN && cfg.pattern_rows == '0);
         if (rx_ff < 0) begin
            rx_in = '0;
            rw_in = rw_ff + rx_ff;
         end
         if (ry_ff < 0) begin
            ry_in = '0;
            rh_in = rh_ff + ry_ff;
         end
      end
      if (cmd.clip2) begin
         // from here on w and h hold the exclusive right and bottom edges
         rw_in = (ex_sum > sw_ext) ? sw_ext : ex_sum;
         rh_in = (ey_sum > sh_ext) ? sh_ext : ey_sum;
      end
   end

   always_comb begin
      clip_left_in   = clip_left_ff;
      clip_right_in  = clip_right_ff;
      clip_bottom_in = clip_bottom_ff;
      cur_col_in     = cur_col_ff;
      cur_row_in     = cur_row_ff;
      prow_in        = prow_ff;
      busy_in        = busy_ff;
      mod_y_in       = mod_y_ff;
      rem_in         = rem_ff;
      mod_cnt_in     = mod_cnt_ff;
      if (cmd.capture) begin
         busy_in = 1'b0;
      end
      if (cmd.check && sts.rect_ok) begin
         clip_left_in   = rx_ff[COORD_BITS-1:0];
         cur_col_in     = rx_ff[COORD_BITS-1:0];
         cur_row_in     = ry_ff[COORD_BITS-1:0];
         clip_right_in  = COORD_BITS'(rw_ff - calc_type'(1));
         clip_bottom_in = COORD_BITS'(rh_ff - calc_type'(1));
         mod_y_in       = ry_ff[COORD_BITS-1:0];
         rem_in         = '0;
         mod_cnt_in     = MOD_CNT_BITS'(COORD_BITS - 1);
      end
      if (cmd.mod_step) begin
         rem_in     = rem_next;
         mod_y_in   = {mod_y_ff[COORD_BITS-2:0], 1'b0};
         mod_cnt_in = mod_cnt_ff - MOD_CNT_BITS'(1);
         if (sts.mod_last) begin
            prow_in = rem_next;
            busy_in = 1'b1;
         end
      end
      if (cmd.pixel && busy_ff) begin
         if (pix_last) begin
            busy_in = 1'b0;
         end else if (cur_col_ff == clip_right_ff) begin
            cur_col_in = clip_left_ff;
            cur_row_in = cur_row_ff + COORD_BITS'(1);
            prow_in    = (prow_inc >= rows_eff) ? '0 : prow_inc[PROW_BITS-1:0];
         end else begin
            cur_col_in = cur_col_ff + COORD_BITS'(1);
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_kind_in   = out_kind_ff;
      out_last_in   = out_last_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      out_right_in  = out_right_ff;
      out_bottom_in = out_bottom_ff;
      out_color_in  = out_color_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.window) begin
         out_valid_in  = 1'b1;
         out_kind_in   = RES_WINDOW;
         out_last_in   = 1'b0;
         out_col_in    = clip_left_ff;
         out_row_in    = cur_row_ff;
         out_right_in  = clip_right_ff;
         out_bottom_in = clip_bottom_ff;
         out_color_in  = '0;
      end else if (cmd.pixel && busy_ff) begin
         out_valid_in  = 1'b1;
         out_kind_in   = RES_PIXEL;
         out_last_in   = pix_last;
         out_col_in    = cur_col_ff;
         out_row_in    = cur_row_ff;
         out_right_in  = '0;
         out_bottom_in = '0;
         out_color_in  = pix_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         mod_cnt_ff   <= '0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         mod_cnt_ff   <= mod_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_ff          <= rx_in;
      ry_ff          <= ry_in;
      rw_ff          <= rw_in;
      rh_ff          <= rh_in;
      rej_ff         <= rej_in;
      clip_left_ff   <= clip_left_in;
      clip_right_ff  <= clip_right_in;
      clip_bottom_ff <= clip_bottom_in;
      cur_col_ff     <= cur_col_in;
      cur_row_ff     <= cur_row_in;
      prow_ff        <= prow_in;
      mod_y_ff       <= mod_y_in;
      rem_ff         <= rem_in;
      out_kind_ff    <= out_kind_in;
      out_last_ff    <= out_last_in;
      out_col_ff     <= out_col_in;
      out_row_ff     <= out_row_in;
      out_right_ff   <= out_right_in;
      out_bottom_ff  <= out_bottom_in;
      out_color_ff   <= out_color_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS-RSP_USED_BITS){1'b0}}, out_color_ff,
                        out_bottom_ff, out_right_ff, out_row_ff, out_col_ff};

endmodule

// ----- design/clipped_rect_pattern_fill.sv -----
// Clipped rectangle fill with a one-bit repeating pattern. A start request
// (tuser 0) is clipped to the screen and, if anything is left (and, in pattern
// mode, the pattern row count is not zero), answered by one address window
// response; it occupies the block through the accept, the clipping states and
// the 11-step restoring remainder unit that finds the starting pattern row,
// then the load of the window response. A rejected start gives no response and
// frees the block after the clip check. Each advance request (tuser 1) gives
// one pixel response, one request a cycle unless a response stalls, from a
// single response register, reloadable in the cycle its content is taken.
// Advances with no rectangle running are dropped; the last pixel has rsp_tlast.
module clipped_rect_pattern_fill import rcpf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // rect_left, rect_top, rect_width, rect_height
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // kind
   input  logic                     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // col_or_left, row_or_top, window_right, window_bottom, pixel_color, zero pad
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // result_kind
   output logic                     rsp_tuser,
   output logic                     rsp_tlast,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   logic signed [RECT_BITS-1:0] rect_left, rect_top, rect_width, rect_height;

   assign rect_left   = $signed(req_tdata[RECT_BITS-1:0]);
   assign rect_top    = $signed(req_tdata[2*RECT_BITS-1:RECT_BITS]);
   assign rect_width  = $signed(req_tdata[3*RECT_BITS-1:2*RECT_BITS]);
   assign rect_height = $signed(req_tdata[4*RECT_BITS-1:3*RECT_BITS]);

   rcpf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rcpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rcpf_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .cfg         (cfg),
      .rect_left   (rect_left),
      .rect_top    (rect_top),
      .rect_width  (rect_width),
      .rect_height (rect_height),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ----- design/rcpf_port_checker.sv -----
// port-level checks on the rectangle fill responses, bound to the top level
module rcpf_port_checker import rcpf_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                     rsp_tuser,
   input logic                     rsp_tlast
);

   // a stalled response keeps its content
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // window responses carry no color and never end a rectangle
   a_window_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == RES_WINDOW |->
         rsp_tdata[RSP_DATA_BITS-1:4*COORD_BITS] == '0 && !rsp_tlast)
      else $error("window response with color or last flag");

   // pixel responses carry zero window edges
   a_pixel_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == RES_PIXEL |->
         rsp_tdata[4*COORD_BITS-1:2*COORD_BITS] == '0)
      else $error("pixel response with window edges");

   // a clipped window is never inverted
   a_window_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == RES_WINDOW |->
         rsp_tdata[COORD_BITS-1:0] <= rsp_tdata[3*COORD_BITS-1:2*COORD_BITS] &&
         rsp_tdata[2*COORD_BITS-1:COORD_BITS] <= rsp_tdata[4*COORD_BITS-1:3*COORD_BITS])
      else $error("window edges out of order");

endmodule

bind clipped_rect_pattern_fill rcpf_port_checker u_port_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
